// ===== design/nnfs_pkg.sv =====
package nnfs_pkg;

   // largest frame dimension in pixels
   localparam int MAX_DIMENSION = 4096;

   // field and register widths
   localparam int DIM_W   = 13;
   localparam int POS_W   = 12;
   localparam int BPP_W   = 3;
   localparam int WORD_W  = 32;
   localparam int ADDR_W  = 26;
   localparam int IDX_W   = 3;
   localparam int NUM_W   = 2 * POS_W;
   localparam int LIN_W   = 2 * POS_W;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_SRC_WIDTH       = 3'd0;
   localparam logic [IDX_W-1:0] CSR_SRC_HEIGHT      = 3'd1;
   localparam logic [IDX_W-1:0] CSR_DST_WIDTH       = 3'd2;
   localparam logic [IDX_W-1:0] CSR_DST_HEIGHT      = 3'd3;
   localparam logic [IDX_W-1:0] CSR_BYTES_PER_PIXEL = 3'd4;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // clamped configuration seen by the back end
   typedef struct packed {
      logic [DIM_W-1:0] src_width;
      logic [DIM_W-1:0] src_height;
      logic [DIM_W-1:0] dst_width;
      logic [DIM_W-1:0] dst_height;
      logic [BPP_W-1:0] bytes_per_pixel;
   } cfg_type;

   // one classified source pixel
   typedef struct packed {
      logic [POS_W-1:0]  column;
      logic [POS_W-1:0]  row;
      logic [WORD_W-1:0] word;
      logic              frame_end;
   } entry_type;

endpackage

// ===== design/nnfs_front.sv =====
module nnfs_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [nnfs_pkg::IDX_W-1:0] csr_index,
   input  logic [nnfs_pkg::DIM_W-1:0] csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [nnfs_pkg::WORD_W-1:0] req_pixel_word,
   input  logic                       q_full,
   output logic                       q_push,
   output nnfs_pkg::entry_type        q_entry,
   output nnfs_pkg::cfg_type          cfg
);

   logic [nnfs_pkg::DIM_W-1:0] src_width_ff, src_width_in;
   logic [nnfs_pkg::DIM_W-1:0] src_height_ff, src_height_in;
   logic [nnfs_pkg::DIM_W-1:0] dst_width_ff, dst_width_in;
   logic [nnfs_pkg::DIM_W-1:0] dst_height_ff, dst_height_in;
   logic [nnfs_pkg::BPP_W-1:0] bpp_ff, bpp_in;
   logic [nnfs_pkg::POS_W-1:0] column_ff, column_in;
   logic [nnfs_pkg::POS_W-1:0] row_ff, row_in;
   logic [nnfs_pkg::DIM_W-1:0] sw_last;
   logic [nnfs_pkg::DIM_W-1:0] sh_last;
   logic                       row_end;
   logic                       frame_end;
   logic                       accept;
   logic [nnfs_pkg::WORD_W-1:0] mask;

   function automatic logic [nnfs_pkg::DIM_W-1:0] clamp_dim(
      input logic [nnfs_pkg::DIM_W-1:0] v
   );
      logic [nnfs_pkg::DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = nnfs_pkg::DIM_W'(1);
      end else if (v > nnfs_pkg::DIM_W'(nnfs_pkg::MAX_DIMENSION)) begin
         r = nnfs_pkg::DIM_W'(nnfs_pkg::MAX_DIMENSION);
      end
      return r;
   endfunction

   function automatic logic [nnfs_pkg::BPP_W-1:0] clamp_bpp(
      input logic [nnfs_pkg::BPP_W-1:0] v
   );
      logic [nnfs_pkg::BPP_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = nnfs_pkg::BPP_W'(1);
      end else if (v > nnfs_pkg::BPP_W'(4)) begin
         r = nnfs_pkg::BPP_W'(4);
      end
      return r;
   endfunction

   // register writes
   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      dst_width_in  = dst_width_ff;
      dst_height_in = dst_height_ff;
      bpp_in        = bpp_ff;
      if (csr_write_enable) begin
         case (csr_index)
            nnfs_pkg::CSR_SRC_WIDTH:       src_width_in  = csr_write_data;
            nnfs_pkg::CSR_SRC_HEIGHT:      src_height_in = csr_write_data;
            nnfs_pkg::CSR_DST_WIDTH:       dst_width_in  = csr_write_data;
            nnfs_pkg::CSR_DST_HEIGHT:      dst_height_in = csr_write_data;
            nnfs_pkg::CSR_BYTES_PER_PIXEL: bpp_in = csr_write_data[nnfs_pkg::BPP_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped view of the sizes
   always_comb begin
      cfg.src_width       = clamp_dim(src_width_ff);
      cfg.src_height      = clamp_dim(src_height_ff);
      cfg.dst_width       = clamp_dim(dst_width_ff);
      cfg.dst_height      = clamp_dim(dst_height_ff);
      cfg.bytes_per_pixel = clamp_bpp(bpp_ff);
   end

   // row and frame end detection
   assign sw_last   = cfg.src_width - nnfs_pkg::DIM_W'(1);
   assign sh_last   = cfg.src_height - nnfs_pkg::DIM_W'(1);
   assign row_end   = {1'b0, column_ff} >= sw_last;
   assign frame_end = row_end && ({1'b0, row_ff} >= sh_last);

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;

   // byte mask for the pixel size
   always_comb begin
      case (cfg.bytes_per_pixel)
         3'd1:    mask = 32'h0000_00FF;
         3'd2:    mask = 32'h0000_FFFF;
         3'd3:    mask = 32'h00FF_FFFF;
         default: mask = 32'hFFFF_FFFF;
      endcase
   end

   always_comb begin
      q_entry.column    = column_ff;
      q_entry.row       = row_ff;
      q_entry.word      = req_pixel_word & mask;
      q_entry.frame_end = frame_end;
   end

   // source position counters
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (accept) begin
         if (row_end) begin
            column_in = '0;
            row_in    = frame_end ? '0 : row_ff + nnfs_pkg::POS_W'(1);
         end else begin
            column_in = column_ff + nnfs_pkg::POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= nnfs_pkg::DIM_W'(1);
         src_height_ff <= nnfs_pkg::DIM_W'(1);
         dst_width_ff  <= nnfs_pkg::DIM_W'(1);
         dst_height_ff <= nnfs_pkg::DIM_W'(1);
         bpp_ff        <= nnfs_pkg::BPP_W'(4);
         column_ff     <= '0;
         row_ff        <= '0;
      end else begin
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         dst_width_ff  <= dst_width_in;
         dst_height_ff <= dst_height_in;
         bpp_ff        <= bpp_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
      end
   end

endmodule

// ===== design/nnfs_queue.sv =====
module nnfs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nnfs_pkg::entry_type push_entry,
   input  logic                pop,
   output nnfs_pkg::entry_type pop_entry,
   output logic                full,
   output logic                empty
);

   nnfs_pkg::entry_type         mem_ff [nnfs_pkg::QUEUE_DEPTH];
   logic [nnfs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [nnfs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [nnfs_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        push_ok;
   logic                        pop_ok;

   assign full      = count_ff == nnfs_pkg::QCNT_W'(nnfs_pkg::QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign push_ok   = push && !full;
   assign pop_ok    = pop && !empty;
   assign pop_entry = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + nnfs_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + nnfs_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + nnfs_pkg::QCNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - nnfs_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= nnfs_pkg::QCNT_W'(nnfs_pkg::QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !pop_ok) |=> count_ff == $past(count_ff) + nnfs_pkg::QCNT_W'(1))
      else $error("queue fill count did not follow a push");

endmodule

// ===== design/nnfs_back.sv =====
module nnfs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  nnfs_pkg::cfg_type            cfg,
   input  logic                         q_empty,
   input  nnfs_pkg::entry_type          q_entry,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [nnfs_pkg::POS_W-1:0]   rsp_dest_column,
   output logic [nnfs_pkg::POS_W-1:0]   rsp_dest_row,
   output logic [nnfs_pkg::ADDR_W-1:0]  rsp_dest_byte_address,
   output logic [nnfs_pkg::WORD_W-1:0]  rsp_write_word,
   output logic                         rsp_frame_end
);

   localparam int STEP_W = $clog2(nnfs_pkg::NUM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(nnfs_pkg::NUM_W - 1);
   localparam int DR_W = nnfs_pkg::DIM_W + nnfs_pkg::NUM_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_DIVIDE,
      ST_SAT,
      ST_LINE,
      ST_ADDR
   } state_type;

   state_type                    state_ff, state_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   nnfs_pkg::entry_type          entry_ff, entry_in;
   logic [nnfs_pkg::DIM_W-1:0]   rem_col_ff, rem_col_in;
   logic [nnfs_pkg::NUM_W-1:0]   quo_col_ff, quo_col_in;
   logic [nnfs_pkg::DIM_W-1:0]   rem_row_ff, rem_row_in;
   logic [nnfs_pkg::NUM_W-1:0]   quo_row_ff, quo_row_in;
   logic [nnfs_pkg::POS_W-1:0]   col_ff, col_in;
   logic [nnfs_pkg::POS_W-1:0]   row_ff, row_in;
   logic [nnfs_pkg::LIN_W-1:0]   lin_ff, lin_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [nnfs_pkg::POS_W-1:0]   out_col_ff, out_col_in;
   logic [nnfs_pkg::POS_W-1:0]   out_row_ff, out_row_in;
   logic [nnfs_pkg::ADDR_W-1:0]  out_addr_ff, out_addr_in;
   logic [nnfs_pkg::WORD_W-1:0]  out_word_ff, out_word_in;
   logic                         out_fe_ff, out_fe_in;
   logic                         out_free;
   logic [DR_W-1:0]              col_step;
   logic [DR_W-1:0]              row_step;
   logic [nnfs_pkg::DIM_W-1:0]   dw_last;
   logic [nnfs_pkg::DIM_W-1:0]   dh_last;
   logic [nnfs_pkg::NUM_W-1:0]   dw_last_ext;
   logic [nnfs_pkg::NUM_W-1:0]   dh_last_ext;

   // one restoring division step: returns {remainder, quotient}
   function automatic logic [DR_W-1:0] div_step(
      input logic [nnfs_pkg::DIM_W-1:0] rem,
      input logic [nnfs_pkg::NUM_W-1:0] quo,
      input logic [nnfs_pkg::DIM_W-1:0] den
   );
      logic [nnfs_pkg::DIM_W:0] shifted;
      logic [nnfs_pkg::DIM_W:0] diff;
      logic [DR_W-1:0]          r;
      shifted = {rem, quo[nnfs_pkg::NUM_W-1]};
      diff    = shifted - {1'b0, den};
      if (shifted >= {1'b0, den}) begin
         r = {diff[nnfs_pkg::DIM_W-1:0], quo[nnfs_pkg::NUM_W-2:0], 1'b1};
      end else begin
         r = {shifted[nnfs_pkg::DIM_W-1:0], quo[nnfs_pkg::NUM_W-2:0], 1'b0};
      end
      return r;
   endfunction

   assign col_step    = div_step(rem_col_ff, quo_col_ff, cfg.src_width);
   assign row_step    = div_step(rem_row_ff, quo_row_ff, cfg.src_height);
   assign dw_last     = cfg.dst_width - nnfs_pkg::DIM_W'(1);
   assign dh_last     = cfg.dst_height - nnfs_pkg::DIM_W'(1);
   assign dw_last_ext = nnfs_pkg::NUM_W'(dw_last);
   assign dh_last_ext = nnfs_pkg::NUM_W'(dh_last);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign q_pop       = (state_ff == ST_IDLE) && !q_empty;

   // sequencer: scale products, column and row division in the same steps, clamp, line index, address build
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      entry_in     = entry_ff;
      rem_col_in   = rem_col_ff;
      quo_col_in   = quo_col_ff;
      rem_row_in   = rem_row_ff;
      quo_row_in   = quo_row_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      lin_in       = lin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_addr_in  = out_addr_ff;
      out_word_in  = out_word_ff;
      out_fe_in    = out_fe_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               entry_in = q_entry;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            quo_col_in = nnfs_pkg::NUM_W'(cfg.dst_width)
                         * nnfs_pkg::NUM_W'(entry_ff.column);
            quo_row_in = nnfs_pkg::NUM_W'(cfg.dst_height)
                         * nnfs_pkg::NUM_W'(entry_ff.row);
            rem_col_in = '0;
            rem_row_in = '0;
            step_in    = '0;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            {rem_col_in, quo_col_in} = col_step;
            {rem_row_in, quo_row_in} = row_step;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            col_in = (quo_col_ff > dw_last_ext) ? dw_last[nnfs_pkg::POS_W-1:0]
                                                : quo_col_ff[nnfs_pkg::POS_W-1:0];
            row_in = (quo_row_ff > dh_last_ext) ? dh_last[nnfs_pkg::POS_W-1:0]
                                                : quo_row_ff[nnfs_pkg::POS_W-1:0];
            state_in = ST_LINE;
         end
         ST_LINE: begin
            lin_in = nnfs_pkg::LIN_W'(row_ff * cfg.dst_width
                     + {{nnfs_pkg::DIM_W{1'b0}}, col_ff});
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_col_in   = col_ff;
               out_row_in   = row_ff;
               out_addr_in  = nnfs_pkg::ADDR_W'(lin_ff)
                              * nnfs_pkg::ADDR_W'(cfg.bytes_per_pixel);
               out_word_in  = entry_ff.word;
               out_fe_in    = entry_ff.frame_end;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff     <= step_in;
      entry_ff    <= entry_in;
      rem_col_ff  <= rem_col_in;
      quo_col_ff  <= quo_col_in;
      rem_row_ff  <= rem_row_in;
      quo_row_ff  <= quo_row_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      lin_ff      <= lin_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_addr_ff <= out_addr_in;
      out_word_ff <= out_word_in;
      out_fe_ff   <= out_fe_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_dest_column       = out_col_ff;
   assign rsp_dest_row          = out_row_ff;
   assign rsp_dest_byte_address = out_addr_ff;
   assign rsp_write_word        = out_word_ff;
   assign rsp_frame_end         = out_fe_ff;

   a_divide_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && step_ff == LAST_STEP) |=> state_ff == ST_SAT)
      else $error("division did not finish after its last step");

   a_result_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADDR && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished result not presented");

endmodule

// ===== design/nearest_neighbor_forward_scaler.sv =====
// flow: a pixel passes the queue, then back end multiply, 24-step divide,
//   clamp, line and address states; the back end works on one pixel at a time;
//   a 4-entry queue lets the front take pixels meanwhile
// reset: synchronous, active high; sizes reset to 1, pixel size to 4,
//   source counters to 0, queue and result register empty
module nearest_neighbor_forward_scaler (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [nnfs_pkg::IDX_W-1:0]   csr_index,
   input  logic [nnfs_pkg::DIM_W-1:0]   csr_write_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [nnfs_pkg::WORD_W-1:0]  req_pixel_word,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [nnfs_pkg::POS_W-1:0]   rsp_dest_column,
   output logic [nnfs_pkg::POS_W-1:0]   rsp_dest_row,
   output logic [nnfs_pkg::ADDR_W-1:0]  rsp_dest_byte_address,
   output logic [nnfs_pkg::WORD_W-1:0]  rsp_write_word,
   output logic                         rsp_frame_end
);

   nnfs_pkg::cfg_type   cfg;
   nnfs_pkg::entry_type push_entry;
   nnfs_pkg::entry_type pop_entry;
   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_empty;

   // counters, registers and pixel classification
   nnfs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_word   (req_pixel_word),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (push_entry),
      .cfg              (cfg)
   );

   // decoupling queue
   nnfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   // scaling, division and address build
   nnfs_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .q_empty               (q_empty),
      .q_entry               (pop_entry),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_dest_column       (rsp_dest_column),
      .rsp_dest_row          (rsp_dest_row),
      .rsp_dest_byte_address (rsp_dest_byte_address),
      .rsp_write_word        (rsp_write_word),
      .rsp_frame_end         (rsp_frame_end)
   );

endmodule
